/* rtl/ewmv_pkg.sv */
// shared types, formats and codes of the ewma mean and variance scorer
package ewmv_pkg;

    // fixed-point formats
    localparam int FRAC_BITS = 16;           // fraction bits of sample, mean, variance, z
    localparam int DATA_W    = 32;
    localparam int WT_W      = 17;           // weight register, q0.16 with 1.0 allowed
    localparam int WT_BITS   = 16;           // fraction bits of the weight
    localparam logic [WT_W-1:0] WT_ONE        = 17'h1_0000;
    localparam logic [WT_W-1:0] WEIGHT_RESET  = 17'd1024;

    // shared multiplier and intermediate widths
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SQ_W   = PROD_W - 1 - FRAC_BITS;  // square of a 32-bit magnitude, rescaled
    localparam int AH_W   = SQ_W - WT_BITS;          // upper slice fed to the multiplier
    localparam int B_W    = SQ_W + 1;                // weighted terms
    localparam int MS_W   = 50;                      // signed mean sum before the shift
    localparam int V_W    = B_W + 2;                 // signed new variance before clamping

    // divider
    localparam int QUO_W     = DATA_W - 1;
    localparam int DIV_STEPS = QUO_W;
    localparam int DCNT_W    = 5;

    // configuration port
    localparam int CFG_AW = 3;
    localparam int CFG_DW = 32;
    typedef enum logic [0:0] {
        REG_WEIGHT = 1'b0
    } t_reg_idx;

    typedef struct packed {
        logic signed [DATA_W-1:0] sample;
        logic                     update;
        logic                     clear;
    } t_in_word;

    typedef struct packed {
        logic signed [DATA_W-1:0] z_score;
        logic signed [DATA_W-1:0] mean_out;
        logic [DATA_W-1:0]        variance_out;
        logic                     limited;
    } t_out_word;

    // one datapath operation per controller step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MU,
        OP_XW,
        OP_MSQ,
        OP_XSQ,
        OP_AHU,
        OP_ALU,
        OP_XHW,
        OP_XLW,
        OP_M2SQ,
        OP_VAR,
        OP_DXSQ,
        OP_DIVSET,
        OP_DIVSTEP,
        OP_OUT
    } t_op;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MU,
        S_XW,
        S_MSQ,
        S_XSQ,
        S_AHU,
        S_ALU,
        S_XHW,
        S_XLW,
        S_M2SQ,
        S_VAR,
        S_DXSQ,
        S_DIVSET,
        S_DIV,
        S_OUT
    } t_state;

    typedef struct packed {
        t_op op;
    } t_cmd;

    typedef struct packed {
        logic div_skip;
        logic out_free;
    } t_stat;

endpackage

/* rtl/ewmv_regs.sv */
// configuration register file with apb-style access
module ewmv_regs (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ewmv_pkg::CFG_AW-1:0]     paddr,
    input  logic [ewmv_pkg::CFG_DW-1:0]     pwdata,
    output logic [ewmv_pkg::CFG_DW-1:0]     prdata,
    output logic                            pready,
    output logic [ewmv_pkg::WT_W-1:0]       o_weight
);

    logic [ewmv_pkg::WT_W-1:0] r_weight;
    logic                      w_hit;

    // byte address 4*i, index sits above the byte offset
    assign w_hit = (paddr[ewmv_pkg::CFG_AW-1] == ewmv_pkg::REG_WEIGHT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_weight <= ewmv_pkg::WEIGHT_RESET;
        end else if (psel && penable && pwrite && w_hit) begin
            r_weight <= pwdata[ewmv_pkg::WT_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_hit) begin
            prdata = {{(ewmv_pkg::CFG_DW - ewmv_pkg::WT_W){1'b0}}, r_weight};
        end
    end

    assign pready   = 1'b1;
    assign o_weight = r_weight;

endmodule

/* rtl/ewmv_ctrl.sv */
// sequencing state machine of the scorer
module ewmv_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_update,
    input  ewmv_pkg::t_stat i_stat,
    output ewmv_pkg::t_cmd  o_cmd,
    output logic            o_in_stall
);

    ewmv_pkg::t_state                r_state, n_state;
    logic [ewmv_pkg::DCNT_W-1:0]     r_div_cnt, n_div_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ewmv_pkg::S_IDLE;
            r_div_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_div_cnt <= n_div_cnt;
        end
    end

    // next state
    always_comb begin
        n_state   = r_state;
        n_div_cnt = r_div_cnt;
        case (r_state)
            ewmv_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = i_in_update ? ewmv_pkg::S_MU : ewmv_pkg::S_DXSQ;
                end
            end
            ewmv_pkg::S_MU:   n_state = ewmv_pkg::S_XW;
            ewmv_pkg::S_XW:   n_state = ewmv_pkg::S_MSQ;
            ewmv_pkg::S_MSQ:  n_state = ewmv_pkg::S_XSQ;
            ewmv_pkg::S_XSQ:  n_state = ewmv_pkg::S_AHU;
            ewmv_pkg::S_AHU:  n_state = ewmv_pkg::S_ALU;
            ewmv_pkg::S_ALU:  n_state = ewmv_pkg::S_XHW;
            ewmv_pkg::S_XHW:  n_state = ewmv_pkg::S_XLW;
            ewmv_pkg::S_XLW:  n_state = ewmv_pkg::S_M2SQ;
            ewmv_pkg::S_M2SQ: n_state = ewmv_pkg::S_VAR;
            ewmv_pkg::S_VAR:  n_state = ewmv_pkg::S_DXSQ;
            ewmv_pkg::S_DXSQ: n_state = ewmv_pkg::S_DIVSET;
            ewmv_pkg::S_DIVSET: begin
                n_div_cnt = '0;
                n_state   = i_stat.div_skip ? ewmv_pkg::S_OUT : ewmv_pkg::S_DIV;
            end
            ewmv_pkg::S_DIV: begin
                if (r_div_cnt == ewmv_pkg::DCNT_W'(ewmv_pkg::DIV_STEPS - 1)) begin
                    n_state = ewmv_pkg::S_OUT;
                end else begin
                    n_div_cnt = r_div_cnt + 1'b1;
                end
            end
            ewmv_pkg::S_OUT: begin
                if (i_stat.out_free) begin
                    n_state = ewmv_pkg::S_IDLE;
                end
            end
            default: n_state = ewmv_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_cmd.op = ewmv_pkg::OP_NONE;
        case (r_state)
            ewmv_pkg::S_IDLE:   o_cmd.op = i_in_valid ? ewmv_pkg::OP_LOAD : ewmv_pkg::OP_NONE;
            ewmv_pkg::S_MU:     o_cmd.op = ewmv_pkg::OP_MU;
            ewmv_pkg::S_XW:     o_cmd.op = ewmv_pkg::OP_XW;
            ewmv_pkg::S_MSQ:    o_cmd.op = ewmv_pkg::OP_MSQ;
            ewmv_pkg::S_XSQ:    o_cmd.op = ewmv_pkg::OP_XSQ;
            ewmv_pkg::S_AHU:    o_cmd.op = ewmv_pkg::OP_AHU;
            ewmv_pkg::S_ALU:    o_cmd.op = ewmv_pkg::OP_ALU;
            ewmv_pkg::S_XHW:    o_cmd.op = ewmv_pkg::OP_XHW;
            ewmv_pkg::S_XLW:    o_cmd.op = ewmv_pkg::OP_XLW;
            ewmv_pkg::S_M2SQ:   o_cmd.op = ewmv_pkg::OP_M2SQ;
            ewmv_pkg::S_VAR:    o_cmd.op = ewmv_pkg::OP_VAR;
            ewmv_pkg::S_DXSQ:   o_cmd.op = ewmv_pkg::OP_DXSQ;
            ewmv_pkg::S_DIVSET: o_cmd.op = ewmv_pkg::OP_DIVSET;
            ewmv_pkg::S_DIV:    o_cmd.op = ewmv_pkg::OP_DIVSTEP;
            ewmv_pkg::S_OUT:    o_cmd.op = ewmv_pkg::OP_OUT;
            default:            o_cmd.op = ewmv_pkg::OP_NONE;
        endcase
    end

    assign o_in_stall = (r_state != ewmv_pkg::S_IDLE);

endmodule

/* rtl/ewmv_datapath.sv */
// statistics registers, shared multiplier, radix-2 divider and output register
module ewmv_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ewmv_pkg::t_cmd                i_cmd,
    input  ewmv_pkg::t_in_word            i_in_word,
    input  logic [ewmv_pkg::WT_W-1:0]     i_weight,
    input  logic                          i_out_stall,
    output ewmv_pkg::t_stat               o_stat,
    output logic                          o_out_valid,
    output ewmv_pkg::t_out_word           o_out_word
);

    // item and statistics
    logic signed [ewmv_pkg::DATA_W-1:0]   r_x;
    logic signed [ewmv_pkg::DATA_W-1:0]   r_mean;
    logic [ewmv_pkg::DATA_W-1:0]          r_var;
    logic [ewmv_pkg::WT_W-1:0]            r_w;
    logic [ewmv_pkg::WT_W-1:0]            r_u;
    logic                                 r_lim;
    logic                                 r_dx_neg;

    // update intermediates
    logic [ewmv_pkg::PROD_W-1:0]          r_prod;
    logic signed [ewmv_pkg::MS_W-1:0]     r_acc;
    logic signed [ewmv_pkg::DATA_W-1:0]   r_m2;
    logic [ewmv_pkg::SQ_W-1:0]            r_a;
    logic [ewmv_pkg::SQ_W-1:0]            r_xs;
    logic [ewmv_pkg::B_W-1:0]             r_b;
    logic [ewmv_pkg::B_W-1:0]             r_c;

    // divider
    logic [ewmv_pkg::DATA_W-1:0]          r_rem;
    logic [ewmv_pkg::QUO_W-1:0]           r_dvd;
    logic [ewmv_pkg::QUO_W-1:0]           r_quo;

    // output register
    logic                                 r_out_valid;
    ewmv_pkg::t_out_word                  r_out;

    logic [ewmv_pkg::WT_W-1:0]            w_wsat;
    logic [ewmv_pkg::MUL_W-1:0]           w_m_mag, w_x_mag, w_m2_mag, w_dx_mag;
    logic signed [ewmv_pkg::DATA_W:0]     w_dx;
    logic [ewmv_pkg::DATA_W:0]            w_dx_abs;
    logic [ewmv_pkg::MUL_W-1:0]           w_opa, w_opb;
    logic [ewmv_pkg::PROD_W-1:0]          w_prod;
    logic                                 w_term_neg;
    logic [ewmv_pkg::MS_W-1:0]            w_term_mag;
    logic signed [ewmv_pkg::MS_W-1:0]     w_term;
    logic signed [ewmv_pkg::MS_W-1:0]     w_msum;
    logic [ewmv_pkg::SQ_W-1:0]            w_sq;
    logic [ewmv_pkg::V_W-1:0]             w_v;
    logic                                 w_v_neg;
    logic                                 w_v_ovf;
    logic                                 w_div_sat;
    logic [ewmv_pkg::DATA_W:0]            w_trial;
    logic                                 w_ge;
    logic [ewmv_pkg::DATA_W:0]            w_diff;
    logic [ewmv_pkg::DATA_W-1:0]          w_z;
    logic                                 w_out_free;

    assign w_wsat   = (i_weight > ewmv_pkg::WT_ONE) ? ewmv_pkg::WT_ONE : i_weight;

    assign w_m_mag  = r_mean[ewmv_pkg::DATA_W-1] ? ewmv_pkg::MUL_W'(-r_mean) : r_mean;
    assign w_x_mag  = r_x[ewmv_pkg::DATA_W-1] ? ewmv_pkg::MUL_W'(-r_x) : r_x;
    assign w_m2_mag = r_m2[ewmv_pkg::DATA_W-1] ? ewmv_pkg::MUL_W'(-r_m2) : r_m2;
    assign w_dx     = {r_x[ewmv_pkg::DATA_W-1], r_x} - {r_mean[ewmv_pkg::DATA_W-1], r_mean};
    assign w_dx_abs = w_dx[ewmv_pkg::DATA_W] ? (~w_dx + 1'b1) : w_dx;
    assign w_dx_mag = w_dx_abs[ewmv_pkg::MUL_W-1:0];

    // operand select of the shared multiplier
    always_comb begin
        w_opa = '0;
        w_opb = '0;
        case (i_cmd.op)
            ewmv_pkg::OP_MU: begin
                w_opa = w_m_mag;
                w_opb = ewmv_pkg::MUL_W'(r_u);
            end
            ewmv_pkg::OP_XW: begin
                w_opa = w_x_mag;
                w_opb = ewmv_pkg::MUL_W'(r_w);
            end
            ewmv_pkg::OP_MSQ: begin
                w_opa = w_m_mag;
                w_opb = w_m_mag;
            end
            ewmv_pkg::OP_XSQ: begin
                w_opa = w_x_mag;
                w_opb = w_x_mag;
            end
            ewmv_pkg::OP_AHU: begin
                w_opa = ewmv_pkg::MUL_W'(r_a[ewmv_pkg::SQ_W-1:ewmv_pkg::WT_BITS]);
                w_opb = ewmv_pkg::MUL_W'(r_u);
            end
            ewmv_pkg::OP_ALU: begin
                w_opa = ewmv_pkg::MUL_W'(r_a[ewmv_pkg::WT_BITS-1:0]);
                w_opb = ewmv_pkg::MUL_W'(r_u);
            end
            ewmv_pkg::OP_XHW: begin
                w_opa = ewmv_pkg::MUL_W'(r_xs[ewmv_pkg::SQ_W-1:ewmv_pkg::WT_BITS]);
                w_opb = ewmv_pkg::MUL_W'(r_w);
            end
            ewmv_pkg::OP_XLW: begin
                w_opa = ewmv_pkg::MUL_W'(r_xs[ewmv_pkg::WT_BITS-1:0]);
                w_opb = ewmv_pkg::MUL_W'(r_w);
            end
            ewmv_pkg::OP_M2SQ: begin
                w_opa = w_m2_mag;
                w_opb = w_m2_mag;
            end
            ewmv_pkg::OP_DXSQ: begin
                w_opa = w_dx_mag;
                w_opb = w_dx_mag;
            end
            default: begin
                w_opa = '0;
                w_opb = '0;
            end
        endcase
    end

    assign w_prod = ewmv_pkg::PROD_W'(w_opa) * ewmv_pkg::PROD_W'(w_opb);

    // signed m*u or x*w from the previous product, then the new mean
    assign w_term_neg = (i_cmd.op == ewmv_pkg::OP_XW) ? r_mean[ewmv_pkg::DATA_W-1]
                                                      : r_x[ewmv_pkg::DATA_W-1];
    assign w_term_mag = r_prod[ewmv_pkg::MS_W-1:0];
    assign w_term     = w_term_neg ? -$signed(w_term_mag) : $signed(w_term_mag);
    assign w_msum     = r_acc + w_term;

    // product rescaled by the fraction bits
    assign w_sq = r_prod[ewmv_pkg::PROD_W-2:ewmv_pkg::FRAC_BITS];

    // var' = b + c - mean'^2, wrapped in a signed word wide enough for both ends
    assign w_v     = ewmv_pkg::V_W'(r_b) + ewmv_pkg::V_W'(r_c) - ewmv_pkg::V_W'(w_sq);
    assign w_v_neg = w_v[ewmv_pkg::V_W-1];
    assign w_v_ovf = |w_v[ewmv_pkg::V_W-2:ewmv_pkg::DATA_W];

    // quotient would not fit in 31 bits
    assign w_div_sat = (r_prod[ewmv_pkg::PROD_W-1:ewmv_pkg::QUO_W] >= {1'b0, r_var});

    assign w_trial = {r_rem, r_dvd[ewmv_pkg::QUO_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_var});
    assign w_diff  = w_trial - {1'b0, r_var};

    assign w_z = r_dx_neg ? ewmv_pkg::DATA_W'(-{1'b0, r_quo}) : {1'b0, r_quo};

    assign w_out_free      = !r_out_valid || !i_out_stall;
    assign o_stat.out_free = w_out_free;
    assign o_stat.div_skip = (r_var == '0) || w_div_sat;

    // running statistics and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mean      <= '0;
            r_var       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.op == ewmv_pkg::OP_LOAD && i_in_word.clear) begin
                r_mean <= '0;
                r_var  <= '0;
            end else if (i_cmd.op == ewmv_pkg::OP_VAR) begin
                r_mean <= r_m2;
                if (w_v_neg) begin
                    r_var <= '0;
                end else if (w_v_ovf) begin
                    r_var <= '1;
                end else begin
                    r_var <= w_v[ewmv_pkg::DATA_W-1:0];
                end
            end
            if (i_cmd.op == ewmv_pkg::OP_OUT && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // working registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;
        case (i_cmd.op)
            ewmv_pkg::OP_LOAD: begin
                r_x   <= i_in_word.sample;
                r_w   <= w_wsat;
                r_u   <= ewmv_pkg::WT_ONE - w_wsat;
                r_lim <= 1'b0;
            end
            ewmv_pkg::OP_XW:   r_acc <= w_term;
            ewmv_pkg::OP_MSQ:  r_m2  <= w_msum[ewmv_pkg::WT_BITS +: ewmv_pkg::DATA_W];
            ewmv_pkg::OP_XSQ:  r_a   <= ewmv_pkg::SQ_W'(r_var) + w_sq;
            ewmv_pkg::OP_AHU:  r_xs  <= w_sq;
            ewmv_pkg::OP_ALU:  r_b   <= r_prod[ewmv_pkg::B_W-1:0];
            ewmv_pkg::OP_XHW:  r_b   <= r_b + ewmv_pkg::B_W'(r_prod >> ewmv_pkg::WT_BITS);
            ewmv_pkg::OP_XLW:  r_c   <= r_prod[ewmv_pkg::B_W-1:0];
            ewmv_pkg::OP_M2SQ: r_c   <= r_c + ewmv_pkg::B_W'(r_prod >> ewmv_pkg::WT_BITS);
            ewmv_pkg::OP_VAR: begin
                if (w_v_neg || w_v_ovf) begin
                    r_lim <= 1'b1;
                end
            end
            ewmv_pkg::OP_DXSQ: r_dx_neg <= w_dx[ewmv_pkg::DATA_W];
            ewmv_pkg::OP_DIVSET: begin
                r_rem <= r_prod[ewmv_pkg::PROD_W-2:ewmv_pkg::QUO_W];
                r_dvd <= r_prod[ewmv_pkg::QUO_W-1:0];
                if (r_var == '0) begin
                    r_quo <= '0;
                end else if (w_div_sat) begin
                    r_quo <= '1;
                    r_lim <= 1'b1;
                end else begin
                    r_quo <= '0;
                end
            end
            ewmv_pkg::OP_DIVSTEP: begin
                r_rem <= w_ge ? w_diff[ewmv_pkg::DATA_W-1:0] : w_trial[ewmv_pkg::DATA_W-1:0];
                r_dvd <= {r_dvd[ewmv_pkg::QUO_W-2:0], 1'b0};
                r_quo <= {r_quo[ewmv_pkg::QUO_W-2:0], w_ge};
            end
            ewmv_pkg::OP_OUT: begin
                if (w_out_free) begin
                    r_out.z_score      <= w_z;
                    r_out.mean_out     <= r_mean;
                    r_out.variance_out <= r_var;
                    r_out.limited      <= r_lim;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

endmodule

/* rtl/ewma_mean_variance_scorer_unit.sv */
// top level of the exponentially weighted mean and variance scorer
//
// input channel: i_in_valid / o_in_stall carry one word {sample, update, clear}.
// a word is taken when i_in_valid is high and o_in_stall is low. clear zeroes
// mean and variance first, update then folds the sample in with the weight
// register, and the sample is scored against the resulting statistics.
// output channel: o_out_valid / i_out_stall return one word per input word:
// {z_score, mean_out, variance_out, limited}, held while i_out_stall is high.
// one word is in flight at a time. a word without update skips the update
// steps; a score with zero variance or a saturated score skips the divide.
// the next word can be taken in the cycle after its result is registered.
// the pace is set by the single shared 32x32 multiplier (ten steps of the
// update) and the radix-2 divider (one quotient bit a cycle).
// if the receiver stalls, the finished result waits in the controller until
// the output register frees, so a held output backs up the input side.
// reset (synchronous, active low) zeroes mean and variance, sets the weight
// register to 1024 and empties the output register.
// weight register at byte address 0 of the apb-style port, 17 bits, q0.16.
module ewma_mean_variance_scorer_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  ewmv_pkg::t_in_word            i_in_word,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output ewmv_pkg::t_out_word           o_out_word,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ewmv_pkg::CFG_AW-1:0]   paddr,
    input  logic [ewmv_pkg::CFG_DW-1:0]   pwdata,
    output logic [ewmv_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready
);

    logic [ewmv_pkg::WT_W-1:0] w_weight;
    ewmv_pkg::t_cmd            w_cmd;
    ewmv_pkg::t_stat           w_stat;

    ewmv_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_weight (w_weight)
    );

    ewmv_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_update (i_in_word.update),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd),
        .o_in_stall  (o_in_stall)
    );

    ewmv_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_in_word   (i_in_word),
        .i_weight    (w_weight),
        .i_out_stall (i_out_stall),
        .o_stat      (w_stat),
        .o_out_valid (o_out_valid),
        .o_out_word  (o_out_word)
    );

    // one word in flight: a taken word blocks the input on the next cycle
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("input taken while a word is in flight");

    // zero variance scores as zero
    a_zero_var_zero_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_word.variance_out == '0)) |-> (o_out_word.z_score == '0))
        else $error("nonzero score with zero variance");

    // the score magnitude is capped below 2^31
    a_z_capped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.z_score != 32'sh8000_0000))
        else $error("score magnitude exceeds its cap");

endmodule

/* tb/sv/tb_ewma_mean_variance_scorer_unit.sv */
// self-checking testbench of the ewma mean and variance scorer unit
`timescale 1ns / 100ps

module tb_ewma_mean_variance_scorer_unit;

    localparam int CLK_HALF_NS     = 4;
    localparam int RESET_CYCLES    = 10;
    localparam int SETTLE_CYCLES   = 60;        // a little over the longest word latency
    localparam int HOLD_CYCLES     = 400;
    localparam int MAX_PRINTS      = 50;
    localparam int PHASE_WORDS     = 200;
    localparam int N_PHASES        = 9;
    localparam int PRESSURE_PHASE  = 5;
    localparam int RAND_WT_PHASE   = 7;
    localparam int UNUSED_WR_PHASE = 3;
    localparam longint TIMEOUT_NS  = 64'd3_000_000 * 2 * CLK_HALF_NS;

    localparam logic [ewmv_pkg::CFG_AW-1:0] ADDR_WEIGHT =
        ewmv_pkg::CFG_AW'(ewmv_pkg::REG_WEIGHT) << 2;
    localparam logic [ewmv_pkg::CFG_AW-1:0] ADDR_UNUSED =
        ADDR_WEIGHT + ewmv_pkg::CFG_AW'(4);  // no register here

    localparam logic [31:0] PH_WDATA [N_PHASES] = '{
        32'd4096, 32'd65536, 32'd0, 32'd1, 32'hFFFF_FFFF,
        32'd32768, 32'd65535, 32'd1024, 32'd1024
    };
    localparam int PH_SEND  [N_PHASES] = '{0, 55, 0, 23, 55, 0, 23, 0, 23};
    localparam int PH_STALL [N_PHASES] = '{0, 0, 55, 23, 0, 55, 23, 0, 23};

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_in_valid;
    logic                              o_in_stall;
    ewmv_pkg::t_in_word                i_in_word;
    logic                              o_out_valid;
    logic                              i_out_stall;
    ewmv_pkg::t_out_word               o_out_word;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [ewmv_pkg::CFG_AW-1:0]       paddr;
    logic [ewmv_pkg::CFG_DW-1:0]       pwdata;
    logic [ewmv_pkg::CFG_DW-1:0]       prdata;
    logic                              pready;

    // predicted state of the scorer
    logic [31:0]                       mean_st   = '0;
    logic [31:0]                       var_st    = '0;
    logic [ewmv_pkg::WT_W-1:0]         weight_st = ewmv_pkg::WEIGHT_RESET;

    ewmv_pkg::t_in_word  pending_words [$];
    ewmv_pkg::t_out_word scored_words  [$];
    int                  n_queued   = 0;
    int                  n_taken    = 0;
    int                  n_checked  = 0;
    int                  fail_count = 0;
    int                  send_pct   = 0;
    int                  stall_pct  = 0;
    logic                word_taken = 1'b0;
    logic                hold_go    = 1'b0;
    logic                out_hold   = 1'b0;

    ewma_mean_variance_scorer_unit i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    function automatic longint unsigned sq_mag(input longint signed v);
        longint unsigned mg;
        mg = (v < 0) ? -v : v;
        return mg * mg;
    endfunction

    // clear, then optional update, then score; advances the predicted state
    task automatic score_sample(input ewmv_pkg::t_in_word wd, output ewmv_pkg::t_out_word res);
        longint signed   x, m, m2, v, dx, wt, uw;
        longint unsigned a, b, c, d, q;
        logic            lim;
        x   = $signed(wd.sample);
        lim = 1'b0;
        if (wd.clear) begin
            mean_st = '0;
            var_st  = '0;
        end
        if (wd.update) begin
            wt = (weight_st > ewmv_pkg::WT_ONE) ? longint'(ewmv_pkg::WT_ONE)
                                                : longint'(weight_st);
            uw = longint'(ewmv_pkg::WT_ONE) - wt;
            m  = $signed(mean_st);
            m2 = (m * uw + x * wt) >>> ewmv_pkg::WT_BITS;
            a  = var_st + (sq_mag(m) >> ewmv_pkg::FRAC_BITS);
            b  = (a * uw) >> ewmv_pkg::WT_BITS;
            c  = ((sq_mag(x) >> ewmv_pkg::FRAC_BITS) * wt) >> ewmv_pkg::WT_BITS;
            d  = sq_mag(m2) >> ewmv_pkg::FRAC_BITS;
            v  = $signed(b + c) - $signed(d);
            if (v < 0) begin
                v   = 0;
                lim = 1'b1;
            end else if (v[63:32] != 0) begin
                v   = 64'h0000_0000_FFFF_FFFF;
                lim = 1'b1;
            end
            mean_st = m2[31:0];
            var_st  = v[31:0];
        end
        res.z_score = '0;
        if (var_st != 0) begin
            m  = $signed(mean_st);
            dx = x - m;
            q  = sq_mag(dx) / var_st;
            if (q > 64'h7FFF_FFFF) begin
                q   = 64'h7FFF_FFFF;
                lim = 1'b1;
            end
            res.z_score = (dx < 0) ? -q[31:0] : q[31:0];
        end
        res.mean_out     = mean_st;
        res.variance_out = var_st;
        res.limited      = lim;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        fail_count++;
        if (fail_count <= MAX_PRINTS)
            $display("mismatch %s at word %0d: got %h, expected %h", what, n_checked, got, want);
    endtask

    // sender: a word stays on the bus until taken
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || word_taken) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_pct) begin
                    i_in_word  <= pending_words.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(negedge i_clk) begin
        if (i_rst_n)
            i_out_stall <= out_hold || ($urandom_range(99) < stall_pct);
    end

    // long receiver hold-off while the sender keeps offering words
    initial begin
        wait (hold_go);
        @(negedge i_clk);
        out_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge i_clk);
        out_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        ewmv_pkg::t_out_word pred;
        ewmv_pkg::t_out_word want;
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            score_sample(i_in_word, pred);
            scored_words.push_back(pred);
            n_taken++;
            word_taken <= 1'b1;
        end else begin
            word_taken <= 1'b0;
        end
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (scored_words.size() == 0) begin
                report_mismatch("unexpected word", o_out_word.z_score, '0);
            end else begin
                want = scored_words.pop_front();
                if (o_out_word.z_score !== want.z_score)
                    report_mismatch("z_score", o_out_word.z_score, want.z_score);
                if (o_out_word.mean_out !== want.mean_out)
                    report_mismatch("mean_out", o_out_word.mean_out, want.mean_out);
                if (o_out_word.variance_out !== want.variance_out)
                    report_mismatch("variance_out", o_out_word.variance_out, want.variance_out);
                if (o_out_word.limited !== want.limited)
                    report_mismatch("limited", 32'(o_out_word.limited), 32'(want.limited));
            end
            n_checked++;
        end
    end

    task automatic queue_word(input logic [31:0] smp, input logic upd, input logic clr);
        ewmv_pkg::t_in_word wd;
        wd.sample = smp;
        wd.update = upd;
        wd.clear  = clr;
        pending_words.push_back(wd);
        n_queued++;
    endtask

    task automatic write_reg(input logic [ewmv_pkg::CFG_AW-1:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_WEIGHT)
            weight_st = data[ewmv_pkg::WT_W-1:0];
    endtask

    task automatic check_weight();
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_WEIGHT;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata !== ewmv_pkg::CFG_DW'(weight_st))
            report_mismatch("weight readback", prdata, ewmv_pkg::CFG_DW'(weight_st));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // wait for every queued word to come back, then let the block settle
    task automatic drain();
        while (n_taken != n_queued || scored_words.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // mostly runs of samples around a level, with noise words mixed in
    task automatic add_random(input int n);
        int          cnt;
        int          len;
        logic [31:0] base;
        logic [31:0] amp;
        logic [31:0] smp;
        cnt = 0;
        while (cnt < n) begin
            if ($urandom_range(99) < 20) begin
                queue_word($urandom, 1'($urandom_range(1)), $urandom_range(7) == 0);
                cnt++;
            end else begin
                base = $signed($urandom) >>> $urandom_range(30, 1);
                amp  = ($urandom_range(5) == 0) ? 32'd0 : (32'd1 << $urandom_range(24)) - 1;
                len  = $urandom_range(30, 4);
                for (int i = 0; i < len && cnt < n; i++) begin
                    smp = base + ($urandom & amp) - (amp >> 1);
                    queue_word(smp, $urandom_range(99) >= 12,
                               (i == 0) ? ($urandom_range(9) < 7) : ($urandom_range(99) < 2));
                    cnt++;
                end
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_out_stall = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        check_weight();

        // reset weight: zero variance, extremes, overflow, clear with update
        queue_word(32'h0000_0000, 1'b0, 1'b0);
        queue_word(32'h7FFF_FFFF, 1'b1, 1'b0);
        queue_word(32'h8000_0000, 1'b1, 1'b0);
        queue_word(32'h8000_0000, 1'b0, 1'b0);
        queue_word(32'h7FFF_FFFF, 1'b0, 1'b0);
        queue_word(32'h0001_0000, 1'b1, 1'b1);
        repeat (4) queue_word(32'h0001_0000, 1'b1, 1'b0);
        queue_word(32'h0000_0000, 1'b0, 1'b1);
        // tiny variance so the score saturates both ways
        queue_word(32'h0000_0800, 1'b1, 1'b1);
        queue_word(32'h7FFF_FFFF, 1'b0, 1'b0);
        queue_word(32'h8000_0000, 1'b0, 1'b0);
        drain();

        // weight of one
        write_reg(ADDR_WEIGHT, 32'd65536);
        check_weight();
        queue_word(32'h1234_5678, 1'b1, 1'b1);
        queue_word(32'h7FFF_FFFF, 1'b1, 1'b0);
        queue_word(32'h8000_0000, 1'b1, 1'b0);
        queue_word(32'h0000_0001, 1'b1, 1'b0);
        queue_word(32'hFFFF_FFFF, 1'b0, 1'b0);
        drain();

        // weight zero leaves the statistics alone
        write_reg(ADDR_WEIGHT, 32'd0);
        check_weight();
        queue_word(32'h7FFF_FFFF, 1'b1, 1'b0);
        queue_word(32'h0000_0005, 1'b1, 1'b0);
        queue_word(32'h8000_0000, 1'b0, 1'b0);
        queue_word(32'h0000_0000, 1'b1, 1'b1);
        drain();

        for (int p = 0; p < N_PHASES; p++) begin
            if (p == RAND_WT_PHASE)
                write_reg(ADDR_WEIGHT, $urandom_range(65536));
            else
                write_reg(ADDR_WEIGHT, PH_WDATA[p]);
            if (p == UNUSED_WR_PHASE)
                write_reg(ADDR_UNUSED, $urandom);
            check_weight();
            send_pct  = PH_SEND[p];
            stall_pct = PH_STALL[p];
            if (p == PRESSURE_PHASE) begin
                send_pct = 0;
                hold_go  = 1'b1;
            end
            add_random(PHASE_WORDS);
            drain();
        end

        if (fail_count == 0 && scored_words.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("*** FAILED ***");
        $finish;
    end

endmodule

/* filelist.f */
rtl/ewmv_pkg.sv
rtl/ewmv_regs.sv
rtl/ewmv_ctrl.sv
rtl/ewmv_datapath.sv
rtl/ewma_mean_variance_scorer_unit.sv
tb/sv/tb_ewma_mean_variance_scorer_unit.sv
